// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== rtl/rwte_pkg.sv =====
// shared types, widths and codes of the random walk traffic estimator
`timescale 1ns / 1ps

package rwte_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 4096;

    localparam int VERT_W   = $clog2(MAX_VERTICES);
    localparam int EDGE_W   = $clog2(MAX_EDGES);
    localparam int VCNT_W   = 11;
    localparam int DEG_W    = 11;
    localparam int CTR_W    = 16;
    localparam int WORD_W   = 32;
    localparam int CNT_W    = 32;
    localparam int SHARE_W  = 32;
    localparam int FRAC_W   = 30;
    localparam int TOT1_W   = 2 * CTR_W;
    localparam int TOTAL_W  = 3 * CTR_W;
    localparam int PROD_W   = WORD_W + DEG_W;
    localparam int ROW_W    = EDGE_W + DEG_W;
    localparam int DIVIDEND_W = CNT_W + FRAC_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int STATE_W  = 4;

    // input beat layout in s_tdata
    localparam int IN_VERTEX_LSB = 0;
    localparam int IN_SLOT_LSB   = IN_VERTEX_LSB + VERT_W;
    localparam int IN_DEG_LSB    = IN_SLOT_LSB + EDGE_W;
    localparam int IN_TARGET_LSB = IN_DEG_LSB + DEG_W;
    localparam int IN_WORD_LSB   = IN_TARGET_LSB + VERT_W;
    localparam int IN_BITS       = IN_WORD_LSB + WORD_W;
    localparam int S_TDATA_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W     = ((CTR_W + SHARE_W + CNT_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [KIND_W-1:0] KIND_ROW  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EDGE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BATCH     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CONVERGED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LIMIT     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DEAD      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd5;

    localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEPS        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AGENTS       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT        = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = 3'd4;

    typedef struct packed {
        logic [VCNT_W-1:0]  vertex_count;
        logic [CTR_W-1:0]   steps;
        logic [CTR_W-1:0]   agents;
        logic [CTR_W-1:0]   limit;
        logic [SHARE_W-1:0] threshold;
    } cfg_t;

    typedef struct packed {
        logic                load_in;
        logic                clear_wr;
        logic                sweep_inc;
        logic                row_wr;
        logic                edge_wr;
        logic                cnt_rd;
        logic                cnt_latch;
        logic                start_mul;
        logic                set_start;
        logic                deg_mul;
        logic                visit_rd;
        logic                step_commit;
        logic                tot1;
        logic                tot2;
        logic                div_start;
        logic                div_commit;
        logic                close_commit;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              finished;
        logic              started;
        logic              dead_end;
        logic              batch_done;
        logic              sweep_last;
        logic              div_done;
        logic              converged;
        logic              limit_hit;
    } dp_sts_t;

    function automatic logic [CTR_W-1:0] at_least_one(input logic [CTR_W-1:0] v);
        at_least_one = (v == '0) ? CTR_W'(1) : v;
    endfunction

endpackage

// ===== rtl/rwte_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module rwte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rwte_div.sv =====
// restoring divider, one quotient bit per cycle, saturating 32-bit quotient
`timescale 1ns / 1ps

module rwte_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [rwte_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [rwte_pkg::TOTAL_W-1:0]      divisor,
    output logic                              done,
    output logic [rwte_pkg::SHARE_W-1:0]      quotient
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [rwte_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [rwte_pkg::TOTAL_W-1:0]     rem_reg, rem_next;
    logic [rwte_pkg::DIVIDEND_W-1:0]  quo_reg, quo_next;
    logic [rwte_pkg::TOTAL_W-1:0]     dvs_reg, dvs_next;
    logic [rwte_pkg::TOTAL_W:0]       trial;
    logic                             fits;

    assign trial = {rem_reg, quo_reg[rwte_pkg::DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? rwte_pkg::TOTAL_W'(trial - {1'b0, dvs_reg})
                            : rwte_pkg::TOTAL_W'(trial);
            quo_next = {quo_reg[rwte_pkg::DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rwte_pkg::DIV_CNT_W'(rwte_pkg::DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    // anything above 32 bits saturates
    assign quotient = (|quo_reg[rwte_pkg::DIVIDEND_W-1:rwte_pkg::SHARE_W]) ? '1
                      : quo_reg[rwte_pkg::SHARE_W-1:0];

endmodule

// ===== rtl/rwte_datapath.sv =====
// datapath: graph and counter memories, walk arithmetic, share sweep
`timescale 1ns / 1ps

module rwte_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rwte_pkg::cfg_t                  cfg,
    input  logic [rwte_pkg::KIND_W-1:0]     in_kind,
    input  logic [rwte_pkg::S_TDATA_W-1:0]  in_data,
    input  rwte_pkg::dp_cmd_t               cmd,
    output rwte_pkg::dp_sts_t               sts,
    output logic [rwte_pkg::STATUS_W-1:0]   out_status,
    output logic [rwte_pkg::CTR_W-1:0]      out_batch,
    output logic [rwte_pkg::SHARE_W-1:0]    out_diff,
    output logic [rwte_pkg::CNT_W-1:0]      out_count
);

    // latched input beat
    logic [rwte_pkg::KIND_W-1:0]  kind_reg;
    logic [rwte_pkg::VERT_W-1:0]  vertex_reg;
    logic [rwte_pkg::EDGE_W-1:0]  slot_reg;
    logic [rwte_pkg::DEG_W-1:0]   degree_reg;
    logic [rwte_pkg::VERT_W-1:0]  target_reg;
    logic [rwte_pkg::WORD_W-1:0]  word_reg;

    // walk state
    logic [rwte_pkg::VERT_W-1:0]  cur_reg;
    logic                         started_reg;
    logic [rwte_pkg::CTR_W-1:0]   step_reg;
    logic [rwte_pkg::CTR_W-1:0]   agent_reg;
    logic [rwte_pkg::CTR_W-1:0]   batch_reg;
    logic                         finished_reg;
    logic [rwte_pkg::SHARE_W-1:0] last_diff_reg;
    logic [rwte_pkg::VERT_W-1:0]  sweep_reg;

    // working registers
    logic [rwte_pkg::PROD_W-1:0]  prod_reg;
    logic [rwte_pkg::EDGE_W-1:0]  start_reg;
    logic                         deg1_reg;
    logic [rwte_pkg::VERT_W-1:0]  tgt_reg;
    logic [rwte_pkg::TOT1_W-1:0]  tot1_reg;
    logic [rwte_pkg::TOTAL_W-1:0] total_reg;
    logic [rwte_pkg::SHARE_W-1:0] sum_reg;
    logic [rwte_pkg::SHARE_W-1:0] prev_reg;
    logic [rwte_pkg::CNT_W-1:0]   count_reg;

    // memory ports
    logic [rwte_pkg::ROW_W-1:0]   row_q;
    logic [rwte_pkg::VERT_W-1:0]  tgt_q;
    logic [rwte_pkg::CNT_W-1:0]   visit_q;
    logic [rwte_pkg::SHARE_W-1:0] prev_q;
    logic [rwte_pkg::VERT_W-1:0]  visit_raddr;
    logic [rwte_pkg::VERT_W-1:0]  visit_waddr;
    logic [rwte_pkg::CNT_W-1:0]   visit_wdata;
    logic                         visit_we;
    logic [rwte_pkg::EDGE_W-1:0]  edge_raddr;

    // effective registers
    logic [rwte_pkg::VCNT_W-1:0]  vc_eff;
    logic [rwte_pkg::CTR_W-1:0]   steps_eff;
    logic [rwte_pkg::CTR_W-1:0]   agents_eff;
    logic [rwte_pkg::CTR_W-1:0]   limit_eff;

    logic [rwte_pkg::EDGE_W-1:0]  row_start;
    logic [rwte_pkg::DEG_W-1:0]   row_deg;
    logic [rwte_pkg::DEG_W-1:0]   mul_b;
    logic [rwte_pkg::DEG_W-1:0]   prod_hi;
    logic [rwte_pkg::EDGE_W-1:0]  idx_e;
    logic [rwte_pkg::CTR_W:0]     step_inc;
    logic [rwte_pkg::CTR_W:0]     agent_inc;
    logic                         agent_done;
    logic                         batch_done;
    logic [rwte_pkg::TOTAL_W-1:0] divisor;
    logic                         div_done;
    logic [rwte_pkg::SHARE_W-1:0] share;
    logic [rwte_pkg::SHARE_W-1:0] diff;
    logic [rwte_pkg::SHARE_W:0]   sum_wide;

    always_comb begin
        if (cfg.vertex_count == '0) begin
            vc_eff = rwte_pkg::VCNT_W'(1);
        end else if (cfg.vertex_count > rwte_pkg::VCNT_W'(rwte_pkg::MAX_VERTICES)) begin
            vc_eff = rwte_pkg::VCNT_W'(rwte_pkg::MAX_VERTICES);
        end else begin
            vc_eff = cfg.vertex_count;
        end
    end

    assign steps_eff  = rwte_pkg::at_least_one(cfg.steps);
    assign agents_eff = rwte_pkg::at_least_one(cfg.agents);
    assign limit_eff  = rwte_pkg::at_least_one(cfg.limit);

    assign row_start = row_q[rwte_pkg::ROW_W-1:rwte_pkg::DEG_W];
    assign row_deg   = row_q[rwte_pkg::DEG_W-1:0];
    assign mul_b     = cmd.start_mul ? rwte_pkg::DEG_W'(vc_eff) : row_deg;
    assign prod_hi   = prod_reg[rwte_pkg::WORD_W +: rwte_pkg::DEG_W];
    assign idx_e     = deg1_reg ? '0 : rwte_pkg::EDGE_W'(prod_hi);
    // slot wraps modulo the edge table size
    assign edge_raddr = start_reg + idx_e;

    assign step_inc   = {1'b0, step_reg} + 1'b1;
    assign agent_inc  = {1'b0, agent_reg} + 1'b1;
    assign agent_done = step_inc >= {1'b0, steps_eff};
    assign batch_done = agent_done && (agent_inc >= {1'b0, agents_eff});

    assign divisor  = (total_reg == '0) ? rwte_pkg::TOTAL_W'(1) : total_reg;
    assign diff     = (share >= prev_reg) ? share - prev_reg : prev_reg - share;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, diff};

    always_comb begin
        if (cmd.cnt_rd) begin
            visit_raddr = vertex_reg;
        end else if (cmd.visit_rd) begin
            visit_raddr = tgt_q;
        end else begin
            visit_raddr = sweep_reg;
        end
        visit_we    = cmd.clear_wr || cmd.step_commit;
        visit_waddr = cmd.clear_wr ? sweep_reg : tgt_reg;
        if (cmd.clear_wr) begin
            visit_wdata = '0;
        end else if (visit_q == '1) begin
            visit_wdata = visit_q;
        end else begin
            visit_wdata = visit_q + rwte_pkg::CNT_W'(1);
        end
    end

    rwte_ram #(.WIDTH(rwte_pkg::ROW_W), .DEPTH(rwte_pkg::MAX_VERTICES)) u_row_ram (
        .aclk  (aclk),
        .we    (cmd.row_wr),
        .waddr (vertex_reg),
        .wdata ({slot_reg, degree_reg}),
        .raddr (cur_reg),
        .rdata (row_q)
    );

    rwte_ram #(.WIDTH(rwte_pkg::VERT_W), .DEPTH(rwte_pkg::MAX_EDGES)) u_edge_ram (
        .aclk  (aclk),
        .we    (cmd.edge_wr),
        .waddr (slot_reg),
        .wdata (target_reg),
        .raddr (edge_raddr),
        .rdata (tgt_q)
    );

    rwte_ram #(.WIDTH(rwte_pkg::CNT_W), .DEPTH(rwte_pkg::MAX_VERTICES)) u_visit_ram (
        .aclk  (aclk),
        .we    (visit_we),
        .waddr (visit_waddr),
        .wdata (visit_wdata),
        .raddr (visit_raddr),
        .rdata (visit_q)
    );

    rwte_ram #(.WIDTH(rwte_pkg::SHARE_W), .DEPTH(rwte_pkg::MAX_VERTICES)) u_prev_ram (
        .aclk  (aclk),
        .we    (cmd.clear_wr || cmd.div_commit),
        .waddr (sweep_reg),
        .wdata (cmd.clear_wr ? '0 : share),
        .raddr (sweep_reg),
        .rdata (prev_q)
    );

    rwte_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend ({visit_q, {rwte_pkg::FRAC_W{1'b0}}}),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (share)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg       <= '0;
            started_reg   <= 1'b0;
            step_reg      <= '0;
            agent_reg     <= '0;
            batch_reg     <= '0;
            finished_reg  <= 1'b0;
            last_diff_reg <= '0;
            sweep_reg     <= '0;
            kind_reg      <= rwte_pkg::KIND_ROW;
        end else begin
            if (cmd.load_in) begin
                kind_reg <= in_kind;
            end
            if (cmd.set_start) begin
                cur_reg     <= prod_hi[rwte_pkg::VERT_W-1:0];
                started_reg <= 1'b1;
                step_reg    <= '0;
            end
            if (cmd.step_commit) begin
                cur_reg <= tgt_reg;
                if (agent_done) begin
                    step_reg    <= '0;
                    started_reg <= 1'b0;
                    if (batch_done) begin
                        agent_reg <= '0;
                        if (batch_reg != '1) begin
                            batch_reg <= batch_reg + 1'b1;
                        end
                    end else begin
                        agent_reg <= agent_inc[rwte_pkg::CTR_W-1:0];
                    end
                end else begin
                    step_reg <= step_inc[rwte_pkg::CTR_W-1:0];
                end
            end
            if (cmd.tot2) begin
                sweep_reg <= '0;
            end else if (cmd.sweep_inc) begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.close_commit) begin
                last_diff_reg <= sum_reg;
                if (sts.converged || sts.limit_hit) begin
                    finished_reg <= 1'b1;
                end
            end
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            vertex_reg <= in_data[rwte_pkg::IN_VERTEX_LSB +: rwte_pkg::VERT_W];
            slot_reg   <= in_data[rwte_pkg::IN_SLOT_LSB +: rwte_pkg::EDGE_W];
            degree_reg <= in_data[rwte_pkg::IN_DEG_LSB +: rwte_pkg::DEG_W];
            target_reg <= in_data[rwte_pkg::IN_TARGET_LSB +: rwte_pkg::VERT_W];
            word_reg   <= in_data[rwte_pkg::IN_WORD_LSB +: rwte_pkg::WORD_W];
            count_reg  <= '0;
        end else if (cmd.cnt_latch) begin
            count_reg <= visit_q;
        end
        if (cmd.start_mul || cmd.deg_mul) begin
            prod_reg <= rwte_pkg::PROD_W'(word_reg) * rwte_pkg::PROD_W'(mul_b);
        end
        if (cmd.deg_mul) begin
            start_reg <= row_start;
            deg1_reg  <= row_deg == rwte_pkg::DEG_W'(1);
        end
        if (cmd.visit_rd) begin
            tgt_reg <= tgt_q;
        end
        if (cmd.tot1) begin
            tot1_reg <= rwte_pkg::TOT1_W'(batch_reg) * rwte_pkg::TOT1_W'(agents_eff);
        end
        if (cmd.tot2) begin
            total_reg <= rwte_pkg::TOTAL_W'(tot1_reg) * rwte_pkg::TOTAL_W'(steps_eff);
            sum_reg   <= '0;
        end else if (cmd.div_commit) begin
            sum_reg <= sum_wide[rwte_pkg::SHARE_W] ? '1 : sum_wide[rwte_pkg::SHARE_W-1:0];
        end
        if (cmd.div_start) begin
            prev_reg <= prev_q;
        end
        if (cmd.out_load) begin
            out_status <= cmd.status;
            out_batch  <= batch_reg;
            out_diff   <= last_diff_reg;
            out_count  <= count_reg;
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.finished   = finished_reg;
    assign sts.started    = started_reg;
    assign sts.dead_end   = row_deg == '0;
    assign sts.batch_done = batch_done;
    assign sts.sweep_last = sweep_reg == rwte_pkg::VERT_W'(rwte_pkg::MAX_VERTICES - 1);
    assign sts.div_done   = div_done;
    assign sts.converged  = sum_reg < cfg.threshold;
    assign sts.limit_hit  = batch_reg >= limit_eff;

endmodule

// ===== rtl/rwte_ctrl.sv =====
// controller state machine: sequences each beat through the datapath
`timescale 1ns / 1ps

module rwte_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  rwte_pkg::dp_sts_t       sts,
    output rwte_pkg::dp_cmd_t       cmd
);

    localparam logic [rwte_pkg::STATE_W-1:0] S_CLEAR  = 4'd0;
    localparam logic [rwte_pkg::STATE_W-1:0] S_IDLE   = 4'd1;
    localparam logic [rwte_pkg::STATE_W-1:0] S_EXEC   = 4'd2;
    localparam logic [rwte_pkg::STATE_W-1:0] S_CNT    = 4'd3;
    localparam logic [rwte_pkg::STATE_W-1:0] S_START  = 4'd4;
    localparam logic [rwte_pkg::STATE_W-1:0] S_ROW    = 4'd5;
    localparam logic [rwte_pkg::STATE_W-1:0] S_SLOT   = 4'd6;
    localparam logic [rwte_pkg::STATE_W-1:0] S_EDGE   = 4'd7;
    localparam logic [rwte_pkg::STATE_W-1:0] S_VISIT  = 4'd8;
    localparam logic [rwte_pkg::STATE_W-1:0] S_TOT1   = 4'd9;
    localparam logic [rwte_pkg::STATE_W-1:0] S_TOT2   = 4'd10;
    localparam logic [rwte_pkg::STATE_W-1:0] S_SWRD   = 4'd11;
    localparam logic [rwte_pkg::STATE_W-1:0] S_SWDAT  = 4'd12;
    localparam logic [rwte_pkg::STATE_W-1:0] S_DIV    = 4'd13;
    localparam logic [rwte_pkg::STATE_W-1:0] S_FIN    = 4'd14;
    localparam logic [rwte_pkg::STATE_W-1:0] S_RESULT = 4'd15;

    logic [rwte_pkg::STATE_W-1:0]  state_reg, state_next;
    logic [rwte_pkg::STATUS_W-1:0] status_reg, status_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_valid_reg;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr  = 1'b1;
                cmd.sweep_inc = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next = rwte_pkg::ST_OK;
                case (sts.kind)
                    rwte_pkg::KIND_ROW: begin
                        cmd.row_wr = 1'b1;
                        state_next = S_RESULT;
                    end
                    rwte_pkg::KIND_EDGE: begin
                        cmd.edge_wr = 1'b1;
                        state_next  = S_RESULT;
                    end
                    rwte_pkg::KIND_READ: begin
                        cmd.cnt_rd = 1'b1;
                        state_next = S_CNT;
                    end
                    rwte_pkg::KIND_DRAW: begin
                        if (sts.finished) begin
                            status_next = rwte_pkg::ST_IGNORED;
                            state_next  = S_RESULT;
                        end else if (!sts.started) begin
                            cmd.start_mul = 1'b1;
                            state_next    = S_START;
                        end else begin
                            // row of the current vertex is read this cycle
                            state_next = S_ROW;
                        end
                    end
                    default: begin
                        status_next = rwte_pkg::ST_IGNORED;
                        state_next  = S_RESULT;
                    end
                endcase
            end
            S_CNT: begin
                cmd.cnt_latch = 1'b1;
                state_next    = S_RESULT;
            end
            S_START: begin
                cmd.set_start = 1'b1;
                state_next    = S_RESULT;
            end
            S_ROW: begin
                if (sts.dead_end) begin
                    status_next = rwte_pkg::ST_DEAD;
                    state_next  = S_RESULT;
                end else begin
                    cmd.deg_mul = 1'b1;
                    state_next  = S_SLOT;
                end
            end
            S_SLOT: begin
                state_next = S_EDGE;
            end
            S_EDGE: begin
                cmd.visit_rd = 1'b1;
                state_next   = S_VISIT;
            end
            S_VISIT: begin
                cmd.step_commit = 1'b1;
                if (sts.batch_done) begin
                    state_next = S_TOT1;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_TOT1: begin
                cmd.tot1   = 1'b1;
                state_next = S_TOT2;
            end
            S_TOT2: begin
                cmd.tot2   = 1'b1;
                state_next = S_SWRD;
            end
            S_SWRD: begin
                state_next = S_SWDAT;
            end
            S_SWDAT: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (sts.div_done) begin
                    cmd.div_commit = 1'b1;
                    if (sts.sweep_last) begin
                        state_next = S_FIN;
                    end else begin
                        cmd.sweep_inc = 1'b1;
                        state_next    = S_SWRD;
                    end
                end
            end
            S_FIN: begin
                cmd.close_commit = 1'b1;
                if (sts.converged) begin
                    status_next = rwte_pkg::ST_CONVERGED;
                end else if (sts.limit_hit) begin
                    status_next = rwte_pkg::ST_LIMIT;
                end else begin
                    status_next = rwte_pkg::ST_BATCH;
                end
                state_next = S_RESULT;
            end
            S_RESULT: begin
                cmd.status = status_reg;
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            status_reg  <= rwte_pkg::ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/random_walk_traffic_estimator_unit.sv =====
// top level of the random walk traffic estimator: ports, registers, glue
//
//  channel   dir   handshake              content
//  s_        in    s_tvalid / s_tready    graph row, edge target, random draw or read
//  m_        out   m_tvalid / m_tready    status, batch number, difference, visit count
//  apb       in    psel, penable, pready  five registers on a 32-bit bus at 4-byte steps
//
// a beat is taken only in the idle state; the result waits in an output register,
// so the next beat is taken while that result still waits on m_tready
// a walk step passes the row, slot, edge and visit states, bound by the chain of
// row, edge and visit memory reads; a batch-ending step adds a sweep of the share
// memory with one divide per vertex; after reset a clearing pass zeroes the visit and
// share memories; no beat is taken until it ends, register writes are taken as ever
`timescale 1ns / 1ps
`include "assert_macros.svh"

module random_walk_traffic_estimator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vertex[9:0], edge_slot[21:10], degree[32:22], target[42:33], random_word[74:43]
    input  logic [rwte_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind[1:0]
    input  logic [rwte_pkg::KIND_W-1:0]       s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // batch_number[15:0], difference[47:16], visit_count[79:48]
    output logic [rwte_pkg::M_TDATA_W-1:0]    m_tdata,
    // status[2:0]
    output logic [rwte_pkg::STATUS_W-1:0]     m_tuser,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rwte_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rwte_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rwte_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    rwte_pkg::cfg_t      cfg_reg, cfg_next;
    rwte_pkg::dp_cmd_t   cmd;
    rwte_pkg::dp_sts_t   sts;
    logic                         cfg_wr;
    logic [rwte_pkg::REG_IDX_W-1:0] reg_idx;
    logic [rwte_pkg::CTR_W-1:0]   out_batch;
    logic [rwte_pkg::SHARE_W-1:0] out_diff;
    logic [rwte_pkg::CNT_W-1:0]   out_count;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rwte_pkg::APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register writes; addresses past the last register are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            case (reg_idx)
                rwte_pkg::REG_VERTEX_COUNT:
                    cfg_next.vertex_count = pwdata[rwte_pkg::VCNT_W-1:0];
                rwte_pkg::REG_STEPS:     cfg_next.steps     = pwdata[rwte_pkg::CTR_W-1:0];
                rwte_pkg::REG_AGENTS:    cfg_next.agents    = pwdata[rwte_pkg::CTR_W-1:0];
                rwte_pkg::REG_LIMIT:     cfg_next.limit     = pwdata[rwte_pkg::CTR_W-1:0];
                rwte_pkg::REG_THRESHOLD: cfg_next.threshold = pwdata[rwte_pkg::SHARE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            rwte_pkg::REG_VERTEX_COUNT:
                prdata = rwte_pkg::APB_DATA_W'(cfg_reg.vertex_count);
            rwte_pkg::REG_STEPS:     prdata = rwte_pkg::APB_DATA_W'(cfg_reg.steps);
            rwte_pkg::REG_AGENTS:    prdata = rwte_pkg::APB_DATA_W'(cfg_reg.agents);
            rwte_pkg::REG_LIMIT:     prdata = rwte_pkg::APB_DATA_W'(cfg_reg.limit);
            rwte_pkg::REG_THRESHOLD: prdata = rwte_pkg::APB_DATA_W'(cfg_reg.threshold);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.vertex_count <= rwte_pkg::VCNT_W'(1);
            cfg_reg.steps        <= rwte_pkg::CTR_W'(1);
            cfg_reg.agents       <= rwte_pkg::CTR_W'(1);
            cfg_reg.limit        <= rwte_pkg::CTR_W'(1);
            cfg_reg.threshold    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rwte_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rwte_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_kind    (s_tuser),
        .in_data    (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_status (m_tuser),
        .out_batch  (out_batch),
        .out_diff   (out_diff),
        .out_count  (out_count)
    );

    // result beat packing, first field lowest
    assign m_tdata = {out_count, out_diff, out_batch};

    // one beat is worked at a time: never two accepts in a row
    `ASSERT_PROP(a_one_beat_in_flight, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    // a loaded result is presented on the next cycle
    `ASSERT_PROP(a_result_shown, aclk, aresetn, cmd.out_load |=> m_tvalid)
    // only defined status codes leave the block
    `ASSERT_NEVER(a_status_code, aclk, aresetn, m_tvalid && (m_tuser > rwte_pkg::ST_IGNORED))
    // the divider never finishes outside the share sweep
    `ASSERT_NEVER(a_div_no_stray, aclk, aresetn, sts.div_done && s_tready)

endmodule
